// ----- design/hsl_pkg.sv -----
// Shared types, constants and transfer-curve tables for the HSL adjust block
// Depends on nothing; imported by hsl_hue_saturation_adjust
`default_nettype none

package hsl_pkg;

  // linear-light precision
  localparam int LIN_BITS = 12;
  localparam int LIN_ONE  = 1 << LIN_BITS;

  // hue is Q0.16 of a turn, one sector is a sixth of a turn
  localparam int HUE_UNIT = 65536;

  // restoring divider: quotient bits and remainder width
  localparam int DIV_STEPS = 18;
  localparam int DIV_DW    = LIN_BITS + 4;
  localparam int REM_W     = (2 * LIN_BITS + 8 > LIN_BITS + 21) ?
                             2 * LIN_BITS + 8 : LIN_BITS + 21;

  // binary search steps over the encode thresholds
  localparam int ENC_STEPS = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SHIFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_OFFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT = 3'd4;

  typedef logic [LIN_BITS:0] lin_t;
  typedef lin_t dec_rom_t [256];
  typedef lin_t enc_rom_t [255];

  // pixel carried alongside the arithmetic
  typedef struct packed {
    logic            byp;
    logic [2:0][7:0] rgb;
    logic [7:0]      a;
  } side_t;

  // Q0.30 product with rounding
  function automatic logic [63:0] qmul30(input logic [63:0] x, input logic [63:0] y);
    return (x * y + 64'd536870912) >> 30;
  endfunction

  // sRGB curve at code m/510, Q0.30
  function automatic logic [63:0] curve_q30(input int m);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] z2;
    logic [63:0] z5;
    int          i;
    if (m <= 20) begin
      return ((64'(5 * m) << 30) + 64'd16473) / 64'd32946;
    end
    u = ((64'(20 * m + 561) << 30) + 64'd5380) / 64'd10761;
    if (u > (64'd1 << 30)) u = 64'd1 << 30;
    u2 = qmul30(u, u);
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        z2  = qmul30(mid, mid);
        z5  = qmul30(qmul30(z2, z2), mid);
        if (z5 <= u2) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return qmul30(u2, lo);
  endfunction

  // decode table: sRGB code to linear, rounded
  function automatic dec_rom_t build_dec();
    dec_rom_t r;
    for (int k = 0; k < 256; k++) begin
      r[k] = lin_t'((curve_q30(2 * k) + (64'd1 << (29 - LIN_BITS))) >> (30 - LIN_BITS));
    end
    return r;
  endfunction

  // encode thresholds: smallest linear value at or above each mid-code edge
  function automatic enc_rom_t build_enc();
    enc_rom_t r;
    for (int k = 0; k < 255; k++) begin
      r[k] = lin_t'((curve_q30(2 * k + 1) + (64'd1 << (30 - LIN_BITS)) - 64'd1)
                    >> (30 - LIN_BITS));
    end
    return r;
  endfunction

  localparam dec_rom_t DEC_ROM = build_dec();
  localparam enc_rom_t ENC_THR = build_enc();

endpackage

`default_nettype wire

// ----- design/hsl_hue_saturation_adjust.sv -----
// Per-pixel HSL hue, saturation and lightness adjust, fully pipelined
// Depends on hsl_pkg (tables, widths, register indexes)
//
// Input channel in_valid/in_ready carries one RGBA8 pixel per transfer,
// output channel out_valid/out_ready returns one adjusted pixel per transfer,
// in order. Alpha passes through; alpha 0 or enable 0 passes the pixel as is.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no pixel is in flight (the block does not enforce this), and
// an index past the last register is ignored. Throughput: one pixel per clock
// while in_ready is high. Pixels pass four front stages (input, decode, min/max,
// HSL setup), an 18-step restoring divider for hue and saturation, five
// HSL-to-RGB stages and an 8-step search of the sRGB encode thresholds, then
// the blend into a two-entry output buffer.
// When the receiver stalls, the buffer absorbs results while the pipeline
// keeps moving; in_ready drops only when the buffer is full and a finished
// result waits at the end of the pipeline. Nothing is lost or repeated.
// Synchronous reset clears the pipeline valid bits, the output buffer and
// the registers (enable 0, hue 0, saturation 1.0, lightness 0, mix 1.0).
`default_nettype none

module hsl_hue_saturation_adjust
  import hsl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           alpha,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                red_out,
  output logic [7:0]                green_out,
  output logic [7:0]                blue_out,
  output logic [7:0]                alpha_out
);

  localparam int LB = LIN_BITS;
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // configuration registers
  logic               enable;
  logic [11:0]        hue_turn;
  logic [15:0]        sat_mult;
  logic signed [13:0] light_bias;
  logic [12:0]        mix_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      hue_turn   <= '0;
      sat_mult   <= 16'd4096;
      light_bias <= '0;
      mix_amount <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_HUE_SHIFT:  hue_turn   <= cfg_data[11:0];
        REG_SAT_SCALE:  sat_mult   <= cfg_data;
        REG_LIGHT_OFFS: light_bias <= cfg_data[13:0];
        REG_MIX_AMOUNT: mix_amount <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // global advance: stall only when the buffer is full and a result waits
  logic       adv;
  logic       en_v [0:ENC_STEPS];
  logic [1:0] ob_cnt;
  assign adv      = !(en_v[ENC_STEPS] && ob_cnt == 2'd2);
  assign in_ready = adv;

  // stage 1: input register
  logic  s1_v;
  side_t s1_side;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side.byp <= !enable || alpha == 8'd0;
      s1_side.rgb <= {blue, green, red};
      s1_side.a   <= alpha;
    end
  end

  // stage 2: sRGB decode
  logic  s2_v;
  side_t s2_side;
  lin_t  s2_lin [3];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side <= s1_side;
      for (int k = 0; k < 3; k++) s2_lin[k] <= DEC_ROM[s1_side.rgb[k]];
    end
  end

  // stage 3: max, min, sum, spread
  logic         s3_v;
  side_t        s3_side;
  lin_t         s3_lin [3];
  logic [LB+1:0] s3_sum;
  lin_t         s3_d;
  logic [1:0]   s3_sec;
  lin_t         c3_mx;
  lin_t         c3_mn;

  always_comb begin
    c3_mx = s2_lin[0];
    c3_mn = s2_lin[0];
    for (int k = 1; k < 3; k++) begin
      if (s2_lin[k] > c3_mx) c3_mx = s2_lin[k];
      if (s2_lin[k] < c3_mn) c3_mn = s2_lin[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side <= s2_side;
      s3_lin  <= s2_lin;
      s3_sum  <= (LB+2)'(c3_mx) + (LB+2)'(c3_mn);
      s3_d    <= c3_mx - c3_mn;
      if (c3_mx == s2_lin[0]) s3_sec <= SEC_RED;
      else if (c3_mx == s2_lin[1]) s3_sec <= SEC_GREEN;
      else s3_sec <= SEC_BLUE;
    end
  end

  // stage 4: lightness, divider operands for saturation and hue
  localparam int LV_W = LB + 18;
  localparam int TW   = LB + 5;

  logic signed [LV_W-1:0] c4_lv;
  logic signed [LV_W-1:0] c4_lvr;
  lin_t                   c4_light;
  lin_t                   c4_den;
  logic signed [TW-1:0]   c4_r;
  logic signed [TW-1:0]   c4_g;
  logic signed [TW-1:0]   c4_b;
  logic signed [TW-1:0]   c4_dd;
  logic signed [TW-1:0]   c4_tot;
  logic [2*LB+7:0]        c4_ds;

  always_comb begin
    // lightness: round((sum/2 + offset) * ONE), clamped
    c4_lv  = (LV_W'(s3_sum) <<< 12) + (LV_W'(light_bias) <<< (LB + 1));
    c4_lvr = (c4_lv + LV_W'(4096)) >>> 13;
    if (c4_lv < 0) c4_light = '0;
    else if (c4_lvr > LV_W'(LIN_ONE)) c4_light = lin_t'(LIN_ONE);
    else c4_light = c4_lvr[LB:0];
    // saturation denominator
    if (s3_sum > (LB+2)'(LIN_ONE)) c4_den = lin_t'((LB+2)'(2 * LIN_ONE) - s3_sum);
    else c4_den = s3_sum[LB:0];
    c4_ds = (2*LB+8)'(s3_d) * (2*LB+8)'(sat_mult);
    // hue sector numerator in sixths of d
    c4_r  = TW'(s3_lin[0]);
    c4_g  = TW'(s3_lin[1]);
    c4_b  = TW'(s3_lin[2]);
    c4_dd = TW'(s3_d);
    case (s3_sec)
      SEC_RED:   c4_tot = c4_g - c4_b + ((c4_g < c4_b) ? TW'(6) * c4_dd : TW'(0));
      SEC_GREEN: c4_tot = TW'(2) * c4_dd + c4_b - c4_r;
      default:   c4_tot = TW'(4) * c4_dd + c4_r - c4_g;
    endcase
    if (c4_tot < 0) c4_tot = '0;
  end

  // divider pipeline, index 0 is stage 4
  logic [REM_W-1:0]     dv_hr [0:DIV_STEPS];
  logic [REM_W-1:0]     dv_sr [0:DIV_STEPS];
  logic [DIV_DW-1:0]    dv_hd [0:DIV_STEPS];
  logic [DIV_DW-1:0]    dv_sd [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_hq [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_sq [0:DIV_STEPS];
  lin_t                 dv_light [0:DIV_STEPS];
  logic                 dv_dz [0:DIV_STEPS];
  side_t                dv_side [0:DIV_STEPS];
  logic                 dv_v [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0]  <= s3_side;
      dv_light[0] <= c4_light;
      dv_dz[0]    <= s3_d == '0;
      dv_sr[0]    <= (REM_W'(c4_ds) << (LB - 10)) + (REM_W'(c4_den) << 1);
      dv_sd[0]    <= DIV_DW'(c4_den) << 2;
      dv_hr[0]    <= (REM_W'(c4_tot[TW-2:0]) << 16) + REM_W'(3 * (LB+3)'(s3_d));
      dv_hd[0]    <= DIV_DW'(6 * (LB+4)'(s3_d));
      dv_hq[0]    <= '0;
      dv_sq[0]    <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [REM_W-1:0] hsh;
    logic [REM_W-1:0] ssh;
    assign hsh = REM_W'(dv_hd[k]) << SH;
    assign ssh = REM_W'(dv_sd[k]) << SH;

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (adv) dv_v[k+1] <= dv_v[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[k+1]  <= dv_side[k];
        dv_light[k+1] <= dv_light[k];
        dv_dz[k+1]    <= dv_dz[k];
        dv_hd[k+1]    <= dv_hd[k];
        dv_sd[k+1]    <= dv_sd[k];
        if (dv_hr[k] >= hsh) begin
          dv_hr[k+1] <= dv_hr[k] - hsh;
          dv_hq[k+1] <= dv_hq[k] | (DIV_STEPS'(1) << SH);
        end else begin
          dv_hr[k+1] <= dv_hr[k];
          dv_hq[k+1] <= dv_hq[k];
        end
        if (dv_sr[k] >= ssh) begin
          dv_sr[k+1] <= dv_sr[k] - ssh;
          dv_sq[k+1] <= dv_sq[k] | (DIV_STEPS'(1) << SH);
        end else begin
          dv_sr[k+1] <= dv_sr[k];
          dv_sq[k+1] <= dv_sq[k];
        end
      end
    end
  end

  // stage 5: saturation clamp, hue rotation
  logic        s5_v;
  side_t       s5_side;
  lin_t        s5_light;
  lin_t        s5_sat;
  logic [15:0] s5_hue;
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (adv) s5_v <= dv_v[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side  <= dv_side[DIV_STEPS];
      s5_light <= dv_light[DIV_STEPS];
      if (dv_dz[DIV_STEPS]) begin
        s5_sat <= '0;
        s5_hue <= {hue_turn, 4'b0000};
      end else begin
        if (dv_sq[DIV_STEPS] > DIV_STEPS'(LIN_ONE)) s5_sat <= lin_t'(LIN_ONE);
        else s5_sat <= dv_sq[DIV_STEPS][LB:0];
        s5_hue <= dv_hq[DIV_STEPS][15:0] + {hue_turn, 4'b0000};
      end
    end
  end

  // stage 6: lightness times saturation
  logic        s6_v;
  side_t       s6_side;
  lin_t        s6_light;
  lin_t        s6_sat;
  lin_t        s6_prod;
  logic [15:0] s6_hue;
  logic [2*LB+1:0] c6_ls;
  assign c6_ls = (2*LB+2)'(s5_light) * (2*LB+2)'(s5_sat) + (2*LB+2)'(LIN_ONE / 2);

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (adv) s6_v <= s5_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side  <= s5_side;
      s6_light <= s5_light;
      s6_sat   <= s5_sat;
      s6_hue   <= s5_hue;
      s6_prod  <= lin_t'(c6_ls >> LB);
    end
  end

  // stage 7: p and q, per-channel hue positions
  localparam int QW = LB + 4;
  logic signed [QW-1:0] c7_l;
  logic signed [QW-1:0] c7_qs;
  logic signed [QW-1:0] c7_ps;
  lin_t                 c7_q;
  lin_t                 c7_p;
  logic [18:0]          c7_t6;
  logic [19:0]          c7_tr;
  logic [19:0]          c7_tb;

  always_comb begin
    c7_l = QW'(s6_light);
    if (QW'(2) * c7_l < QW'(LIN_ONE)) c7_qs = c7_l + QW'(s6_prod);
    else c7_qs = c7_l + QW'(s6_sat) - QW'(s6_prod);
    c7_ps = QW'(2) * c7_l - c7_qs;
    if (c7_qs < 0) c7_q = '0;
    else if (c7_qs > QW'(LIN_ONE)) c7_q = lin_t'(LIN_ONE);
    else c7_q = c7_qs[LB:0];
    if (c7_ps < 0) c7_p = '0;
    else if (c7_ps > QW'(LIN_ONE)) c7_p = lin_t'(LIN_ONE);
    else c7_p = c7_ps[LB:0];
    if (c7_p > c7_q) c7_p = c7_q;
    // six sectors per turn; red leads by two, blue by four
    c7_t6 = (19'(s6_hue) << 2) + (19'(s6_hue) << 1);
    c7_tr = 20'(c7_t6) + 20'(2 * HUE_UNIT);
    c7_tb = 20'(c7_t6) + 20'(4 * HUE_UNIT);
    if (c7_tr >= 20'(6 * HUE_UNIT)) c7_tr = c7_tr - 20'(6 * HUE_UNIT);
    if (c7_tb >= 20'(6 * HUE_UNIT)) c7_tb = c7_tb - 20'(6 * HUE_UNIT);
  end

  logic        s7_v;
  side_t       s7_side;
  lin_t        s7_light;
  logic        s7_grey;
  lin_t        s7_p;
  lin_t        s7_q;
  logic [18:0] s7_t [3];
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (adv) s7_v <= s6_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side  <= s6_side;
      s7_light <= s6_light;
      s7_grey  <= s6_sat == '0;
      s7_p     <= c7_p;
      s7_q     <= c7_q;
      s7_t[0]  <= c7_tr[18:0];
      s7_t[1]  <= c7_t6;
      s7_t[2]  <= c7_tb[18:0];
    end
  end

  // stage 8: ramp weight per channel, full weight reaches q, zero stays at p
  logic [16:0] c8_frac [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s7_t[k] < 19'(HUE_UNIT)) c8_frac[k] = s7_t[k][16:0];
      else if (s7_t[k] < 19'(3 * HUE_UNIT)) c8_frac[k] = 17'(HUE_UNIT);
      else if (s7_t[k] < 19'(4 * HUE_UNIT)) c8_frac[k] = 17'(19'(4 * HUE_UNIT) - s7_t[k]);
      else c8_frac[k] = '0;
    end
  end

  logic        s8_v;
  side_t       s8_side;
  lin_t        s8_light;
  logic        s8_grey;
  lin_t        s8_p;
  lin_t        s8_span;
  logic [16:0] s8_frac [3];
  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (adv) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_side  <= s7_side;
      s8_light <= s7_light;
      s8_grey  <= s7_grey;
      s8_p     <= s7_p;
      s8_span  <= s7_q - s7_p;
      s8_frac  <= c8_frac;
    end
  end

  // stage 9: ramp value, or lightness for a grey result
  logic [LB+17:0] c9_m [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c9_m[k] = (LB+18)'(s8_span) * (LB+18)'(s8_frac[k]) + (LB+18)'(HUE_UNIT / 2);
    end
  end

  lin_t       en_x [0:ENC_STEPS][3];
  logic [7:0] en_n [0:ENC_STEPS][3];
  side_t      en_side [0:ENC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) en_v[0] <= 1'b0;
    else if (adv) en_v[0] <= s8_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      en_side[0] <= s8_side;
      for (int k = 0; k < 3; k++) begin
        en_n[0][k] <= '0;
        if (s8_grey) en_x[0][k] <= s8_light;
        else en_x[0][k] <= s8_p + lin_t'(c9_m[k] >> 16);
      end
    end
  end

  // sRGB encode: binary search of the thresholds, one code bit per stage
  for (genvar e = 0; e < ENC_STEPS; e++) begin : g_enc
    localparam int BIT = ENC_STEPS - 1 - e;
    logic [7:0] cand [3];
    always_comb begin
      for (int k = 0; k < 3; k++) cand[k] = en_n[e][k] | (8'd1 << BIT);
    end

    always_ff @(posedge clk) begin
      if (rst) en_v[e+1] <= 1'b0;
      else if (adv) en_v[e+1] <= en_v[e];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        en_side[e+1] <= en_side[e];
        en_x[e+1]    <= en_x[e];
        for (int k = 0; k < 3; k++) begin
          if (en_x[e][k] >= ENC_THR[cand[k] - 8'd1]) en_n[e+1][k] <= cand[k];
          else en_n[e+1][k] <= en_n[e][k];
        end
      end
    end
  end

  // blend with the original pixel
  logic [12:0]        bl_m;
  logic signed [8:0]  bl_diff [3];
  logic signed [23:0] bl_acc [3];
  logic [31:0]        bl_pix;
  side_t              bl_side;

  always_comb begin
    bl_side = en_side[ENC_STEPS];
    bl_m    = (mix_amount > 13'd4096) ? 13'd4096 : mix_amount;
    for (int k = 0; k < 3; k++) begin
      bl_diff[k] = 9'({1'b0, en_n[ENC_STEPS][k]}) - 9'({1'b0, bl_side.rgb[k]});
      bl_acc[k]  = (24'({1'b0, bl_side.rgb[k]}) <<< 12)
                   + 24'(bl_diff[k]) * 24'($signed({1'b0, bl_m})) + 24'sd2048;
    end
    if (bl_side.byp) begin
      bl_pix = {bl_side.rgb[0], bl_side.rgb[1], bl_side.rgb[2], bl_side.a};
    end else begin
      bl_pix = {bl_acc[0][19:12], bl_acc[1][19:12], bl_acc[2][19:12], bl_side.a};
    end
  end

  // two-entry output buffer
  logic [31:0] ob_data [2];
  logic        ob_wr;
  logic        ob_rd;
  logic        ob_push;
  logic        ob_pop;
  assign ob_push   = en_v[ENC_STEPS] && adv;
  assign ob_pop    = out_valid && out_ready;
  assign out_valid = ob_cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (ob_push) ob_wr <= !ob_wr;
      if (ob_pop) ob_rd <= !ob_rd;
      if (ob_push && !ob_pop) ob_cnt <= ob_cnt + 2'd1;
      else if (!ob_push && ob_pop) ob_cnt <= ob_cnt - 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (ob_push) ob_data[ob_wr] <= bl_pix;
  end

  assign red_out   = ob_data[ob_rd][31:24];
  assign green_out = ob_data[ob_rd][23:16];
  assign blue_out  = ob_data[ob_rd][15:8];
  assign alpha_out = ob_data[ob_rd][7:0];

  // buffer occupancy stays within its two entries
  a_ob_bound: assert property (@(posedge clk) disable iff (rst) ob_cnt != 2'd3)
    else $error("output buffer count out of range");

  // a push without a pop never lands on a full buffer
  a_ob_push: assert property (@(posedge clk) disable iff (rst)
    (ob_push && !ob_pop) |-> ob_cnt != 2'd2)
    else $error("push into full output buffer");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
